// ----- rtl/indexed_insert_delete_list_unit_assert.svh -----
// Assertion macros for the list unit; all sample on clk and are off during reset.
`ifndef INDEXED_INSERT_DELETE_LIST_UNIT_ASSERT_SVH
`define INDEXED_INSERT_DELETE_LIST_UNIT_ASSERT_SVH

// Implication in the same cycle.
`define IIDL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define IIDL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/iidl_pkg.sv -----
package iidl_pkg;

	localparam int CAPACITY = 16;

	localparam int CMD_W = 3;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int STS_W = 2;
	localparam int LEN_W = 5;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT     = 3'd0,
		CMD_DELETE     = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_PUSH_FRONT = 3'd3,
		CMD_POP_BACK   = 3'd4,
		CMD_POP_FRONT  = 3'd5,
		CMD_READ       = 3'd6,
		CMD_WRITE      = 3'd7
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 2'd0,
		STS_BAD_INDEX = 2'd1,
		STS_EMPTY     = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_t;

endpackage

// ----- rtl/indexed_insert_delete_list_unit.sv -----
// Ordered list of up to 16 signed words with insert, delete, push, pop,
// read and write by index. Issue a command by raising start while busy is
// low; busy then stays high for one cycle while the list is updated, and in
// the cycle after that done pulses for exactly one cycle with status,
// read_value and length. The receiver cannot stall: capture the result in
// the done cycle or it is lost. A new command may be issued in the same
// cycle that done is high, but not while busy; the controller loads each
// command and then executes it, and every element moves to its neighbor
// in parallel within the execute cycle.
`include "indexed_insert_delete_list_unit_assert.svh"

module indexed_insert_delete_list_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [iidl_pkg::CMD_W-1:0]    cmd,
	input  logic [iidl_pkg::POS_W-1:0]    position,
	input  logic signed [iidl_pkg::VAL_W-1:0] value,
	output logic                          done,
	output logic [iidl_pkg::STS_W-1:0]    status,
	output logic signed [iidl_pkg::VAL_W-1:0] read_value,
	output logic [iidl_pkg::LEN_W-1:0]    length
);
	import iidl_pkg::*;

	ctrl_t ctrl;

	iidl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	iidl_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cmd        (cmd),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.length     (length)
	);

	`IIDL_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted item did not raise busy")
	`IIDL_ASSERT_NEXT(a_exec_done, busy, done && !busy, "execute cycle gave no result")
	`IIDL_ASSERT_NOW(a_done_idle, done, !busy && !ctrl.exec, "result while still executing")
	`IIDL_ASSERT_NOW(a_read_zero, done && status != STS_OK, read_value == '0, "failed command returned data")

endmodule

// ----- rtl/iidl_ctrl.sv -----
module iidl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output iidl_pkg::ctrl_t   ctrl
);
	import iidl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy      = (state_q == ST_EXEC);
	assign ctrl.load = (state_q == ST_IDLE) && start;
	assign ctrl.exec = (state_q == ST_EXEC);

endmodule

// ----- rtl/iidl_dpath.sv -----
module iidl_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iidl_pkg::ctrl_t               ctrl,
	input  logic [iidl_pkg::CMD_W-1:0]    cmd,
	input  logic [iidl_pkg::POS_W-1:0]    position,
	input  logic signed [iidl_pkg::VAL_W-1:0] value,
	output logic                          done,
	output logic [iidl_pkg::STS_W-1:0]    status,
	output logic signed [iidl_pkg::VAL_W-1:0] read_value,
	output logic [iidl_pkg::LEN_W-1:0]    length
);
	import iidl_pkg::*;

	cmd_t                cmd_q;
	logic [POS_W-1:0]    pos_q;
	logic [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]    count_q;
	logic [VAL_W-1:0]    elems_q [CAPACITY];
	logic [VAL_W-1:0]    elems_nxt [CAPACITY];

	logic                done_q;
	status_t             status_q;
	logic [VAL_W-1:0]    rdval_q;
	logic [LEN_W-1:0]    length_q;

	logic [CMP_W-1:0]    pos_c;
	logic [CMP_W-1:0]    cnt_c;
	logic                is_empty;
	logic                is_full;
	status_t             sts_c;
	logic                ok_c;
	logic                shift_up;
	logic                shift_dn;
	logic                put;
	logic [CMP_W-1:0]    at_c;
	logic [CMP_W-1:0]    put_at;
	logic [CNT_W-1:0]    count_nxt;

	assign pos_c    = CMP_W'(pos_q);
	assign cnt_c    = CMP_W'(count_q);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q >= CNT_W'(CAPACITY));

	always_comb begin
		sts_c = STS_OK;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (pos_c > cnt_c)  sts_c = STS_BAD_INDEX;
				else if (is_full)   sts_c = STS_FULL;
			end
			CMD_DELETE, CMD_READ, CMD_WRITE: begin
				if (is_empty)            sts_c = STS_EMPTY;
				else if (pos_c >= cnt_c) sts_c = STS_BAD_INDEX;
			end
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (is_full) sts_c = STS_FULL;
			end
			CMD_POP_BACK, CMD_POP_FRONT: begin
				if (is_empty) sts_c = STS_EMPTY;
			end
			default: begin
				sts_c = STS_OK;
			end
		endcase
	end

	assign ok_c     = (sts_c == STS_OK);
	assign shift_up = ok_c && (cmd_q == CMD_INSERT || cmd_q == CMD_PUSH_FRONT);
	assign shift_dn = ok_c && (cmd_q == CMD_DELETE || cmd_q == CMD_POP_FRONT);
	assign put      = ok_c && (cmd_q == CMD_INSERT || cmd_q == CMD_PUSH_FRONT ||
	                           cmd_q == CMD_PUSH_BACK || cmd_q == CMD_WRITE);
	assign at_c     = (cmd_q == CMD_INSERT || cmd_q == CMD_DELETE) ? pos_c : '0;

	always_comb begin
		case (cmd_q)
			CMD_PUSH_BACK:  put_at = cnt_c;
			CMD_PUSH_FRONT: put_at = '0;
			default:        put_at = pos_c;
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ok_c) begin
			case (cmd_q)
				CMD_INSERT, CMD_PUSH_BACK, CMD_PUSH_FRONT: count_nxt = count_q + 1'b1;
				CMD_DELETE, CMD_POP_BACK, CMD_POP_FRONT:   count_nxt = count_q - 1'b1;
				default:                                   count_nxt = count_q;
			endcase
		end
	end

	// Each entry takes from its own neighbor, so the whole tail moves together in the execute cycle.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
		localparam logic [CMP_W-1:0] IDX = CMP_W'(g);
		localparam int LO = (g > 0) ? g - 1 : 0;
		localparam int HI = (g < CAPACITY - 1) ? g + 1 : CAPACITY - 1;
		always_comb begin
			elems_nxt[g] = elems_q[g];
			if (put && IDX == put_at)
				elems_nxt[g] = val_q;
			else if (shift_up && g > 0 && IDX > at_c)
				elems_nxt[g] = elems_q[LO];
			else if (shift_dn && g < CAPACITY - 1 && IDX >= at_c)
				elems_nxt[g] = elems_q[HI];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			for (int i = 0; i < CAPACITY; i++) begin
				elems_q[i] <= elems_nxt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd_t'(cmd);
			pos_q <= position;
			val_q <= value;
		end
		if (ctrl.exec) begin
			status_q <= sts_c;
			length_q <= LEN_W'(count_nxt);
			rdval_q  <= (ok_c && cmd_q == CMD_READ) ? elems_q[pos_c[IDX_W-1:0]] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctrl.exec;
			if (ctrl.exec) count_q <= count_nxt;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = rdval_q;
	assign length     = length_q;

endmodule
